// File: hdl/ffl_pkg.sv
// shared types and constants for the first-fit free list
`default_nettype none
package ffl_pkg;

    localparam int SLOTS      = 16;
    localparam int OFFSET_W   = 32;
    localparam int LENGTH_W   = 16;
    localparam int IN_DATA_W  = OFFSET_W + LENGTH_W;
    localparam int OUT_DATA_W = OFFSET_W + LENGTH_W;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_FIT    = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FIT      = 2'd2,
        ST_NO_FIT   = 2'd3
    } status_t;

    // contents of one slot as seen by its neighbor
    typedef struct packed {
        logic                valid;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } slot_t;

    // scan wave handed from cell to cell
    typedef struct packed {
        logic                wave;
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } carry_t;

    // broadcast controls from the top level to every cell
    typedef struct packed {
        logic                ins_en;
        logic [OFFSET_W-1:0] ins_offset;
        logic [LENGTH_W-1:0] ins_length;
        logic [LENGTH_W-1:0] fit_size;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/ffl_cell.sv
// one slot of the free list with its scan and compaction step
`default_nettype none
module ffl_cell
    import ffl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       prev_valid,
    input  wire slot_t      next_slot,
    input  wire carry_t     carry_in,
    output carry_t          carry_out,
    output slot_t           slot
);

    logic                valid_reg, valid_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [LENGTH_W-1:0] length_reg, length_next;
    logic                wave_reg, found_reg;
    logic [OFFSET_W-1:0] carry_off_reg, carry_off_next;

    logic hit;
    logic found_now;
    logic shift;
    logic ins_here;

    always_comb begin
        hit       = valid_reg && (length_reg >= ctrl.fit_size);
        found_now = carry_in.found || hit;
        shift     = carry_in.wave && found_now;
        // append lands in the first empty slot behind a full one
        ins_here  = ctrl.ins_en && prev_valid && !valid_reg;

        valid_next  = valid_reg;
        offset_next = offset_reg;
        length_next = length_reg;
        if (shift) begin
            valid_next  = next_slot.valid;
            offset_next = next_slot.offset;
            length_next = next_slot.length;
        end else if (ins_here) begin
            valid_next  = 1'b1;
            offset_next = ctrl.ins_offset;
            length_next = ctrl.ins_length;
        end

        carry_off_next = carry_in.found ? carry_in.offset : offset_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            wave_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            wave_reg  <= carry_in.wave;
            found_reg <= carry_in.wave && found_now;
        end
    end

    always_ff @(posedge aclk) begin
        offset_reg    <= offset_next;
        length_reg    <= length_next;
        carry_off_reg <= carry_off_next;
    end

    assign slot.valid       = valid_reg;
    assign slot.offset      = offset_reg;
    assign slot.length      = length_reg;
    assign carry_out.wave   = wave_reg;
    assign carry_out.found  = found_reg;
    assign carry_out.offset = carry_off_reg;

endmodule
`default_nettype wire

// File: hdl/first_fit_free_space_list.sv
// first-fit free list: a row of slot cells with a command front end
//
// s_ channel takes one command per beat: s_tuser is the command (0 insert,
// 1 fit), s_tdata carries the hole offset and the size. m_ channel returns
// one result per command: m_tuser is the status, m_tdata the granted offset
// and length (zero unless a fit was found).
// an insert appends to the first empty cell at the accepting edge; its status
// is held in the result registers, then moves into the output register and
// shows on m_tvalid once that is free, and the next command is taken after that.
// a fit sends a scan wave down the row of SLOTS cells, one cell per cycle;
// each cell from the first fitting hole onward takes its neighbor's contents,
// so the list closes up as the wave passes. once the wave leaves the last
// cell the result goes through the result and output registers as for an insert,
// and the next command is taken after it. the command rate is set by that wave.
// one result may wait in the output register while the next command is
// taken; a further result stays in the block until the receiver takes the
// waiting one, and no command is taken meanwhile.
// after reset the list is empty and both channels are idle.
`default_nettype none
module first_fit_free_space_list
    import ffl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // hole_offset[31:0], size_bytes[47:32]
    input  wire logic                  s_tuser,   // cmd
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // granted_offset[31:0], granted_length[47:32]
    output logic [1:0]                 m_tuser    // status
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                  s_beat;
    cmd_t                  cmd;
    logic [OFFSET_W-1:0]   in_offset;
    logic [LENGTH_W-1:0]   in_size;

    logic [LENGTH_W-1:0]   size_reg, size_next;
    logic                  start_reg, start_next;

    status_t               res_status_reg, res_status_next;
    logic [OFFSET_W-1:0]   res_offset_reg, res_offset_next;
    logic [LENGTH_W-1:0]   res_length_reg, res_length_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]            m_tuser_reg, m_tuser_next;
    logic                  out_free;

    cell_ctrl_t            ctrl;
    slot_t                 slots [SLOTS];
    carry_t                carry [SLOTS+1];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_beat    = s_tvalid && s_tready;
    assign cmd       = cmd_t'(s_tuser);
    assign in_offset = s_tdata[OFFSET_W-1:0];
    assign in_size   = s_tdata[IN_DATA_W-1:OFFSET_W];
    assign out_free  = !m_tvalid_reg || m_tready;

    assign ctrl.ins_en     = s_beat && (cmd == CMD_INSERT);
    assign ctrl.ins_offset = in_offset;
    assign ctrl.ins_length = in_size;
    assign ctrl.fit_size   = size_reg;

    assign carry[0].wave   = start_reg;
    assign carry[0].found  = 1'b0;
    assign carry[0].offset = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic  prev_valid;
        slot_t next_slot;
        if (i == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_prev
            assign prev_valid = slots[i-1].valid;
        end
        if (i == SLOTS - 1) begin : g_last
            assign next_slot = '0;
        end else begin : g_next
            assign next_slot = slots[i+1];
        end
        ffl_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_valid (prev_valid),
            .next_slot  (next_slot),
            .carry_in   (carry[i]),
            .carry_out  (carry[i+1]),
            .slot       (slots[i])
        );
    end

    always_comb begin
        state_next      = state_reg;
        size_next       = size_reg;
        start_next      = 1'b0;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        res_length_next = res_length_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    if (cmd == CMD_INSERT) begin
                        res_status_next = slots[SLOTS-1].valid ? ST_FULL : ST_INSERTED;
                        res_offset_next = '0;
                        res_length_next = '0;
                        state_next      = S_WAIT;
                    end else begin
                        size_next  = in_size;
                        start_next = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (carry[SLOTS].wave) begin
                    if (carry[SLOTS].found) begin
                        res_status_next = ST_FIT;
                        res_offset_next = carry[SLOTS].offset;
                        res_length_next = size_reg;
                    end else begin
                        res_status_next = ST_NO_FIT;
                        res_offset_next = '0;
                        res_length_next = '0;
                    end
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_length_reg, res_offset_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            start_reg    <= start_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_length_reg <= res_length_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

// File: dv/tb_first_fit_free_space_list.sv
// self-checking testbench for the first-fit free list: directed table, then random traffic
module tb_first_fit_free_space_list;
    timeunit 1ns;
    timeprecision 1ps;
    import ffl_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [OFFSET_W-1:0] off;
        logic [LENGTH_W-1:0] len;
    } grant_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [OFFSET_W-1:0] off;
        logic [LENGTH_W-1:0] size;
        logic                typed;
        grant_t              want;
    } stim_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // hole_offset[31:0], size_bytes[47:32]
    logic                  s_tuser  = 1'b0; // cmd
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // granted_offset[31:0], granted_length[47:32]
    logic [1:0]            m_tuser;         // status

    // shadow of the free list
    logic [OFFSET_W-1:0] free_offsets [SLOTS];
    logic [LENGTH_W-1:0] free_lengths [SLOTS];
    int                  free_count = 0;

    grant_t    pending_grants [$];
    stim_row_t stim_table [$];
    grant_t    seen_grant;
    int        mismatches = 0;
    bit        calm = 1'b0;

    first_fit_free_space_list u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic grant_t predict_grant(cmd_t cmd, logic [OFFSET_W-1:0] off,
                                             logic [LENGTH_W-1:0] size);
        grant_t g;
        int     hit;
        g.status = ST_NO_FIT;
        g.off    = '0;
        g.len    = '0;
        hit      = -1;
        if (cmd == CMD_INSERT) begin
            if (free_count >= SLOTS) begin
                g.status = ST_FULL;
            end else begin
                free_offsets[free_count] = off;
                free_lengths[free_count] = size;
                free_count++;
                g.status = ST_INSERTED;
            end
        end else begin
            // oldest hole that is long enough, exact fit included
            for (int i = 0; i < free_count; i++)
                if (hit < 0 && free_lengths[i] >= size) hit = i;
            if (hit >= 0) begin
                g.status = ST_FIT;
                g.off    = free_offsets[hit];
                g.len    = size;
                for (int i = hit; i + 1 < free_count; i++) begin
                    free_offsets[i] = free_offsets[i + 1];
                    free_lengths[i] = free_lengths[i + 1];
                end
                free_count--;
            end
        end
        return g;
    endfunction

    task automatic add_row(cmd_t cmd, logic [OFFSET_W-1:0] off, logic [LENGTH_W-1:0] size,
                           logic typed, status_t st, logic [OFFSET_W-1:0] goff,
                           logic [LENGTH_W-1:0] glen);
        stim_row_t r;
        r.cmd         = cmd;
        r.off         = off;
        r.size        = size;
        r.typed       = typed;
        r.want.status = st;
        r.want.off    = goff;
        r.want.len    = glen;
        stim_table.push_back(r);
    endtask

    // drive one command beat, wait for the handshake, then book its expected result
    task automatic send_beat(cmd_t cmd, logic [OFFSET_W-1:0] off, logic [LENGTH_W-1:0] size,
                             logic typed, grant_t want);
        grant_t g;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {size, off};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        g = predict_grant(cmd, off, size);
        pending_grants.push_back(typed ? want : g);
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_DATA_W'({$urandom, $urandom});
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_grants.size() != 0) @(posedge aclk);
    endtask

    // receiver: ready runs with random stall bursts, always ready near the end
    initial begin
        int n;
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 40);
            end else begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 17);
            end
            repeat (n) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual status %0d data %h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                seen_grant = pending_grants.pop_front();
                if (m_tuser != seen_grant.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, seen_grant.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[OFFSET_W-1:0] != seen_grant.off) begin
                    $display("%0t: granted_offset mismatch: expected %h, actual %h",
                             $time, seen_grant.off, m_tdata[OFFSET_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[OUT_DATA_W-1:OFFSET_W] != seen_grant.len) begin
                    $display("%0t: granted_length mismatch: expected %h, actual %h",
                             $time, seen_grant.len, m_tdata[OUT_DATA_W-1:OFFSET_W]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        stim_row_t           r;
        cmd_t                cmd;
        logic [OFFSET_W-1:0] off;
        logic [LENGTH_W-1:0] size;
        int                  bias;
        int                  kind;
        int                  pick;

        // directed table
        add_row(CMD_FIT,    32'h0,        16'h0,    1'b1, ST_NO_FIT,   32'h0,        16'h0);
        add_row(CMD_FIT,    32'h0,        16'hFFFF, 1'b1, ST_NO_FIT,   32'h0,        16'h0);
        add_row(CMD_INSERT, 32'h0,        16'h0,    1'b1, ST_INSERTED, 32'h0,        16'h0);
        add_row(CMD_INSERT, 32'hFFFFFFFF, 16'hFFFF, 1'b1, ST_INSERTED, 32'h0,        16'h0);
        // zero request takes the oldest hole, here the zero-length one
        add_row(CMD_FIT,    32'h0,        16'h0,    1'b1, ST_FIT,      32'h0,        16'h0);
        // exact fit on the largest length
        add_row(CMD_FIT,    32'h0,        16'hFFFF, 1'b1, ST_FIT,      32'hFFFFFFFF, 16'hFFFF);
        add_row(CMD_FIT,    32'h0,        16'h0,    1'b1, ST_NO_FIT,   32'h0,        16'h0);
        for (int i = 0; i < SLOTS; i++)
            add_row(CMD_INSERT, 32'h1 << (2 * i), LENGTH_W'(16'h0100 * (i + 1)), 1'b0,
                    ST_INSERTED, 32'h0, 16'h0);
        add_row(CMD_INSERT, 32'hA5A5A5A5, 16'h5A5A, 1'b1, ST_FULL,     32'h0,        16'h0);
        add_row(CMD_FIT,    32'h0,        16'hFFFF, 1'b1, ST_NO_FIT,   32'h0,        16'h0);
        // exact fit in the middle of the list
        add_row(CMD_FIT,    32'h0,        16'h0800, 1'b0, ST_NO_FIT,   32'h0,        16'h0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i]) begin
            r = stim_table[i];
            send_beat(r.cmd, r.off, r.size, r.typed, r.want);
            maybe_pause();
        end
        drain_results();

        for (int n = 0; n < 1500; n++) begin
            if (n == 700) drain_results();
            if (n == 1350) calm = 1'b1;
            // insert share moves between phases so the list fills and drains
            case ((n / 100) % 6)
                0: bias = 80;
                1: bias = 30;
                2: bias = 60;
                3: bias = 20;
                4: bias = 92;
                default: bias = 45;
            endcase
            cmd  = ($urandom_range(1, 100) <= bias) ? CMD_INSERT : CMD_FIT;
            off  = $urandom;
            kind = $urandom_range(0, 9);
            if (cmd == CMD_INSERT) begin
                case (kind)
                    0: size = 16'h0;
                    1: size = 16'hFFFF;
                    2, 3: size = LENGTH_W'($urandom);
                    default: size = LENGTH_W'($urandom_range(0, 4095));
                endcase
            end else begin
                case (kind)
                    0: size = 16'h0;
                    1: size = 16'hFFFF;
                    2, 3, 4: begin
                        if (free_count > 0) begin
                            pick = $urandom_range(0, free_count - 1);
                            size = free_lengths[pick];
                            if (size != 0 && $urandom_range(0, 1) == 1) size = size - 1'b1;
                        end else begin
                            size = LENGTH_W'($urandom_range(0, 4095));
                        end
                    end
                    5: size = LENGTH_W'($urandom);
                    default: size = LENGTH_W'($urandom_range(0, 4095));
                endcase
            end
            send_beat(cmd, off, size, 1'b0, '0);
            maybe_pause();
        end
        s_tvalid <= 1'b0;

        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (4 * SLOTS) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
